@@ rtl/similarity_inlier_scoring_assert.svh @@
// Assertion macros shared by the similarity inlier scoring RTL.
`ifndef SIMILARITY_INLIER_SCORING_ASSERT_SVH
`define SIMILARITY_INLIER_SCORING_ASSERT_SVH
`ifndef SYNTHESIS
`define SIS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SIS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SIS_ASSERT(label, clk, rst_n, prop, msg)
`define SIS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

@@ rtl/sis_pkg.sv @@
// Types, constants and codes shared by the similarity inlier scoring block.
package sis_pkg;

  localparam int CMD_W      = 2;
  localparam int IDX_W      = 4;
  localparam int DATA_W     = 32;
  localparam int THR_W      = 63;
  localparam int PIDX_W     = 12;
  localparam int CNT_W      = 13;
  localparam int NUM_COEFS  = 12;
  localparam int T_BASE     = 9;
  localparam int MUL_W      = 33;
  localparam int DIST_W     = 64;

  localparam int MAX_POINTS_DEF  = 4096;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SCORE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_SCORE,
    OP_CLEAR
  } sis_op_e;

  typedef struct packed {
    sis_op_e            op;
    logic [IDX_W-1:0]   coef_index;
    logic [DATA_W-1:0]  coef_value;
    logic [DATA_W-1:0]  src_x;
    logic [DATA_W-1:0]  src_y;
    logic [DATA_W-1:0]  src_z;
    logic [DATA_W-1:0]  dst_x;
    logic [DATA_W-1:0]  dst_y;
    logic [DATA_W-1:0]  dst_z;
    logic               last_pair;
  } sis_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_ADDT,
    ST_SQ,
    ST_SUM,
    ST_DONE
  } sis_state_e;

endpackage

@@ rtl/sis_if.sv @@
// Channel interfaces: command input, result output and threshold write.
interface sis_in_if import sis_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic [IDX_W-1:0]         coef_index;
  logic signed [DATA_W-1:0] coef_value;
  logic signed [DATA_W-1:0] src_x;
  logic signed [DATA_W-1:0] src_y;
  logic signed [DATA_W-1:0] src_z;
  logic signed [DATA_W-1:0] dst_x;
  logic signed [DATA_W-1:0] dst_y;
  logic signed [DATA_W-1:0] dst_z;
  logic                     last_pair;

  modport source (output valid, cmd, coef_index, coef_value, src_x, src_y, src_z,
                  dst_x, dst_y, dst_z, last_pair, input ready);
  modport sink (input valid, cmd, coef_index, coef_value, src_x, src_y, src_z,
                dst_x, dst_y, dst_z, last_pair, output ready);
endinterface

interface sis_out_if import sis_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              is_inlier;
  logic [PIDX_W-1:0] pair_index;
  logic [CNT_W-1:0]  inlier_total;
  logic              beats_best;
  logic [CNT_W-1:0]  best_total;
  logic              final_pair;

  modport source (output valid, is_inlier, pair_index, inlier_total, beats_best,
                  best_total, final_pair, input ready);
  modport sink (input valid, is_inlier, pair_index, inlier_total, beats_best,
                best_total, final_pair, output ready);
endinterface

interface sis_cfg_if import sis_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [THR_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ rtl/similarity_inlier_scoring.sv @@
// The back end scores a pair with three axes of three multiplies, translation,
// square and sum on one shared multiplier, then registers its result word in ST_DONE
// when the output is free. Load and clear words are handled straight from ST_IDLE.
// Input words are taken one per cycle while the four-entry queue has room.
// Reset (rst_ni low, asynchronous) clears counts, threshold, queue and output valid;
// coefficients stay undefined until loaded.
module similarity_inlier_scoring import sis_pkg::*; #(
  parameter int MAX_POINTS  = MAX_POINTS_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sis_in_if.sink     in_i,
  sis_out_if.source  out_o,
  sis_cfg_if.sink    cfg_i
);

`include "similarity_inlier_scoring_assert.svh"

  logic [THR_W-1:0] thr_q;
  logic             q_valid;
  logic             q_pop;
  sis_entry_t       q_entry;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_i.valid) begin
      thr_q <= cfg_i.data;
    end
  end

  sis_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_valid_o (q_valid),
    .q_entry_o (q_entry),
    .q_pop_i   (q_pop)
  );

  sis_back #(
    .MAX_POINTS  (MAX_POINTS),
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_entry_i (q_entry),
    .q_pop_o   (q_pop),
    .thr_i     (thr_q),
    .out_o     (out_o)
  );

  `SIS_ASSERT(a_beat_sets_best, clk_i, rst_ni, out_o.valid && out_o.beats_best |-> out_o.best_total == out_o.inlier_total, "new best count differs from the pass total")
  `SIS_ASSERT(a_beat_only_last, clk_i, rst_ni, out_o.valid && !out_o.final_pair |-> !out_o.beats_best, "best count beaten on a pair that is not last")
  `SIS_ASSERT(a_inlier_counted, clk_i, rst_ni, out_o.valid && out_o.is_inlier |-> out_o.inlier_total != 0, "inlier word with an empty running total")
  `SIS_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !out_o.valid, "result word shown right after reset")

endmodule

@@ rtl/sis_front.sv @@
// Front end: accepts command words, classifies them and queues the useful ones.
module sis_front import sis_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  sis_in_if.sink     in_i,
  output logic       q_valid_o,
  output sis_entry_t q_entry_o,
  input  logic       q_pop_i
);

  sis_entry_t        mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              keep;
  logic              push;
  logic              pop;
  sis_entry_t        entry;

  // Loads to a slot past the table and the unused command are dropped here.
  always_comb begin
    entry            = '0;
    keep             = 1'b0;
    entry.coef_index = in_i.coef_index;
    entry.coef_value = in_i.coef_value;
    entry.src_x      = in_i.src_x;
    entry.src_y      = in_i.src_y;
    entry.src_z      = in_i.src_z;
    entry.dst_x      = in_i.dst_x;
    entry.dst_y      = in_i.dst_y;
    entry.dst_z      = in_i.dst_z;
    entry.last_pair  = in_i.last_pair;
    case (in_i.cmd)
      CMD_LOAD: begin
        entry.op = OP_LOAD;
        keep     = (in_i.coef_index < IDX_W'(NUM_COEFS));
      end
      CMD_SCORE: begin
        entry.op = OP_SCORE;
        keep     = 1'b1;
      end
      CMD_CLEAR: begin
        entry.op = OP_CLEAR;
        keep     = 1'b1;
      end
      default: begin
        entry.op = OP_LOAD;
        keep     = 1'b0;
      end
    endcase
  end

  assign in_i.ready = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign q_valid_o  = (count_q != '0);
  assign q_entry_o  = mem_q[rd_ptr_q];

  assign push = in_i.valid && in_i.ready && keep;
  assign pop  = q_pop_i && q_valid_o;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

endmodule

@@ rtl/sis_back.sv @@
// Back end: holds the transform, scores one pair at a time and keeps the counts.
module sis_back import sis_pkg::*; #(
  parameter int MAX_POINTS  = MAX_POINTS_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  sis_entry_t       q_entry_i,
  output logic             q_pop_o,
  input  logic [THR_W-1:0] thr_i,
  sis_out_if.source        out_o
);

  localparam int RAW_W = 2 * COORD_WIDTH - FRAC_BITS;
  localparam int ACC_W = ((RAW_W > COORD_WIDTH) ? RAW_W : COORD_WIDTH) + 3;
  localparam int PC_W  = $clog2(MAX_POINTS);
  localparam int RI_W  = $clog2(MAX_POINTS + 1);

  sis_state_e               state_q, state_d;
  logic [1:0]               axis_q, axis_d;
  logic [1:0]               step_q, step_d;
  logic [PC_W-1:0]          pc_q, pc_d;
  logic [RI_W-1:0]          ri_q, ri_d;
  logic [RI_W-1:0]          best_q, best_d;
  logic                     out_valid_q, out_valid_d;

  logic [DATA_W-1:0]        coef_q [NUM_COEFS];
  logic                     coef_we;
  logic [IDX_W-1:0]         coef_ra;
  logic [DATA_W-1:0]        coef_rd;

  sis_entry_t               cur_q, cur_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [2*MUL_W-1:0] prod_q, prod_d;
  logic [DIST_W-1:0]        dist_q, dist_d;
  logic                     sat_q, sat_d;

  logic                     inl_q, inl_d;
  logic [PIDX_W-1:0]        pidx_q, pidx_d;
  logic [CNT_W-1:0]         itot_q, itot_d;
  logic                     beats_q, beats_d;
  logic [CNT_W-1:0]         btot_q, btot_d;
  logic                     fin_q, fin_d;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic [DATA_W-1:0]        src_sel, dst_sel;
  logic signed [2*MUL_W-1:0] prod_shr;
  logic [DIST_W-1:0]        abs_e;
  logic [DIST_W-1:0]        sq_term;
  logic [DIST_W:0]          dist_sum;
  logic                     inlier;
  logic [RI_W-1:0]          ri_new;
  logic                     beats;
  logic                     out_free;

  assign coef_rd = coef_q[coef_ra];

  always_comb begin
    case (step_q)
      2'd0:    src_sel = cur_q.src_x;
      2'd1:    src_sel = cur_q.src_y;
      default: src_sel = cur_q.src_z;
    endcase
    case (axis_q)
      2'd0:    dst_sel = cur_q.dst_x;
      2'd1:    dst_sel = cur_q.dst_y;
      default: dst_sel = cur_q.dst_z;
    endcase
  end

  // One shared multiplier: coefficient times coordinate, or the square of
  // one error component.
  always_comb begin
    if (acc_q < 0) begin
      abs_e = -DIST_W'(acc_q);
    end else begin
      abs_e = DIST_W'(acc_q);
    end
    if (state_q == ST_SQ) begin
      mul_a = signed'({1'b0, abs_e[31:0]});
      mul_b = signed'({1'b0, abs_e[31:0]});
    end else begin
      mul_a = MUL_W'(signed'(coef_rd[COORD_WIDTH-1:0]));
      mul_b = MUL_W'(signed'(src_sel[COORD_WIDTH-1:0]));
    end
    prod_d   = mul_a * mul_b;
    prod_shr = prod_q >>> FRAC_BITS;
  end

  always_comb begin
    sq_term  = sat_q ? '1 : prod_q[DIST_W-1:0];
    dist_sum = {1'b0, dist_q} + {1'b0, sq_term};
    inlier   = (dist_q < {1'b0, thr_i});
    if (inlier && (ri_q < RI_W'(MAX_POINTS))) begin
      ri_new = ri_q + 1'b1;
    end else begin
      ri_new = ri_q;
    end
    beats    = cur_q.last_pair && (ri_new > best_q);
    out_free = !out_valid_q || out_o.ready;
  end

  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    step_d      = step_q;
    pc_d        = pc_q;
    ri_d        = ri_q;
    best_d      = best_q;
    out_valid_d = out_valid_q && !out_o.ready;
    cur_d       = cur_q;
    acc_d       = acc_q;
    dist_d      = dist_q;
    sat_d       = sat_q;
    inl_d       = inl_q;
    pidx_d      = pidx_q;
    itot_d      = itot_q;
    beats_d     = beats_q;
    btot_d      = btot_q;
    fin_d       = fin_q;
    q_pop_o     = 1'b0;
    coef_we     = 1'b0;
    coef_ra     = '0;

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          case (q_entry_i.op)
            OP_LOAD: begin
              coef_we = 1'b1;
            end
            OP_CLEAR: begin
              best_d = '0;
            end
            OP_SCORE: begin
              cur_d   = q_entry_i;
              acc_d   = '0;
              dist_d  = '0;
              axis_d  = '0;
              step_d  = '0;
              state_d = ST_MUL;
            end
            default: begin
              coef_we = 1'b0;
            end
          endcase
        end
      end
      ST_MUL: begin
        coef_ra = IDX_W'({axis_q, 1'b0}) + IDX_W'(axis_q) + IDX_W'(step_q);
        state_d = ST_ACC;
      end
      ST_ACC: begin
        // An arithmetic shift of the product is the floor of the scaled term.
        acc_d = acc_q + ACC_W'(prod_shr);
        if (step_q == 2'd2) begin
          state_d = ST_ADDT;
        end else begin
          step_d  = step_q + 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_ADDT: begin
        coef_ra = IDX_W'(T_BASE) + IDX_W'(axis_q);
        acc_d   = acc_q + ACC_W'(signed'(coef_rd[COORD_WIDTH-1:0]))
                        - ACC_W'(signed'(dst_sel[COORD_WIDTH-1:0]));
        state_d = ST_SQ;
      end
      ST_SQ: begin
        sat_d   = |abs_e[DIST_W-1:32];
        state_d = ST_SUM;
      end
      ST_SUM: begin
        dist_d = dist_sum[DIST_W] ? '1 : dist_sum[DIST_W-1:0];
        acc_d  = '0;
        step_d = '0;
        if (axis_q == 2'd2) begin
          state_d = ST_DONE;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          inl_d       = inlier;
          pidx_d      = PIDX_W'(pc_q);
          itot_d      = CNT_W'(ri_new);
          beats_d     = beats;
          btot_d      = beats ? CNT_W'(ri_new) : CNT_W'(best_q);
          fin_d       = cur_q.last_pair;
          if (beats) begin
            best_d = ri_new;
          end
          if (cur_q.last_pair) begin
            pc_d = '0;
            ri_d = '0;
          end else begin
            ri_d = ri_new;
            if (pc_q < PC_W'(MAX_POINTS - 1)) begin
              pc_d = pc_q + 1'b1;
            end
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= '0;
      step_q      <= '0;
      pc_q        <= '0;
      ri_q        <= '0;
      best_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      step_q      <= step_d;
      pc_q        <= pc_d;
      ri_q        <= ri_d;
      best_q      <= best_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_q[q_entry_i.coef_index] <= q_entry_i.coef_value;
    end
    cur_q   <= cur_d;
    acc_q   <= acc_d;
    prod_q  <= prod_d;
    dist_q  <= dist_d;
    sat_q   <= sat_d;
    inl_q   <= inl_d;
    pidx_q  <= pidx_d;
    itot_q  <= itot_d;
    beats_q <= beats_d;
    btot_q  <= btot_d;
    fin_q   <= fin_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.is_inlier    = inl_q;
  assign out_o.pair_index   = pidx_q;
  assign out_o.inlier_total = itot_q;
  assign out_o.beats_best   = beats_q;
  assign out_o.best_total   = btot_q;
  assign out_o.final_pair   = fin_q;

endmodule
